// ===== rtl/rcra_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rcra_pkg
// Shared types and constants for the reference-counted register allocator.
// ============================================================================
package rcra_pkg;

    // Default sizing of the allocator.
    localparam int NUM_REGS_DEF   = 32;
    localparam int NUM_VARS_DEF   = 26;
    localparam int COUNT_BITS_DEF = 8;

    // Fixed widths of the request and result fields.
    localparam int OP_W      = 2;
    localparam int VAR_W     = 5;
    localparam int REG_W     = 5;
    localparam int REG_NUM_W = 5;
    localparam int STATUS_W  = 2;
    localparam int FIRST_W   = 5;

    // Configuration register file.
    localparam int              APB_DATA_W         = 32;
    localparam int              APB_ADDR_W         = 3;
    localparam logic            CFG_IDX_FIRST_ALLOC = 1'b0;
    localparam logic [FIRST_W-1:0] FIRST_ALLOC_RESET = 5'd5;

    typedef enum logic [OP_W-1:0] {
        OP_ASSIGN_VAR = 2'd0,
        OP_ASSIGN_TMP = 2'd1,
        OP_RELEASE    = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOREG  = 2'd1,
        ST_UNUSED = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
    } rcra_cmd_t;

endpackage

// ===== rtl/rcra_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rcra_ctrl
// Request sequencer: capture, count lookup, execute and result strobe.
// ============================================================================
module rcra_ctrl
    import rcra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output rcra_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign cmd.capture = start && (state_reg == S_IDLE);
    assign cmd.lookup  = (state_reg == S_LOOKUP);
    assign cmd.exec    = (state_reg == S_EXEC);

endmodule

// ===== rtl/rcra_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rcra_datapath
// Count table, variable map, in-use vector, free search and result logic.
// ============================================================================
module rcra_datapath
    import rcra_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEF,
    parameter int NUM_VARS   = NUM_VARS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcra_cmd_t            cmd,
    input  logic [FIRST_W-1:0]   first_alloc_reg,
    input  logic [OP_W-1:0]      operation,
    input  logic [VAR_W-1:0]     var_index,
    input  logic [REG_W-1:0]     reg_index,
    output logic [REG_NUM_W-1:0] reg_number,
    output logic                 sole_use,
    output logic [STATUS_W-1:0]  status
);

    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int VIDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Count table and variable map. An entry whose in-use or valid bit is
    // clear is treated as zero or unmapped, so neither memory needs a reset.
    logic [COUNT_BITS-1:0] cnt_mem [NUM_REGS];
    logic [RIDX_W-1:0]     map_mem [NUM_VARS];

    logic [NUM_REGS-1:0] in_use_reg;
    logic [NUM_REGS-1:0] in_use_next;
    logic [NUM_VARS-1:0] map_valid_reg;
    logic [NUM_VARS-1:0] map_valid_next;

    // Request captured at acceptance.
    op_t               op_reg;
    logic              named_reg;
    logic [VIDX_W-1:0] var_addr_reg;
    logic [RIDX_W-1:0] reg_addr_reg;
    logic              reg_ok_reg;
    logic              map_hit_reg;
    logic [RIDX_W-1:0] map_rd_reg;
    logic              free_found_reg;
    logic [RIDX_W-1:0] free_idx_reg;

    // Count lookup.
    logic [RIDX_W-1:0]     target_reg;
    logic                  live_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;

    // Result registers.
    logic [REG_NUM_W-1:0] reg_number_reg;
    logic                 sole_use_reg;
    status_t              status_reg;

    logic [VIDX_W-1:0]   var_addr;
    logic [RIDX_W-1:0]   reg_addr;
    logic                named;
    logic                reg_ok;
    logic [NUM_REGS-1:0] avail;
    logic [NUM_REGS-1:0] lowest;
    logic [RIDX_W-1:0]   free_idx;
    logic [RIDX_W-1:0]   target;

    logic [COUNT_BITS-1:0] cur;
    logic [RIDX_W-1:0]     rnum;
    logic                  sole;
    status_t               st;
    logic                  cnt_we;
    logic [RIDX_W-1:0]     cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  map_we;

    assign var_addr = VIDX_W'(var_index);
    assign reg_addr = RIDX_W'(reg_index);
    assign named    = (op_t'(operation) == OP_ASSIGN_VAR) && (32'(var_index) < NUM_VARS);
    assign reg_ok   = (32'(reg_index) < NUM_REGS);

    // Free search: the lowest free register at or above the first allocatable
    // one is isolated by the two's complement trick and then encoded.
    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            avail[i] = !in_use_reg[i] && (i >= int'(first_alloc_reg));
        end
        lowest   = avail & (~avail + NUM_REGS'(1));
        free_idx = '0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            free_idx = free_idx | (lowest[i] ? RIDX_W'(i) : RIDX_W'(0));
        end
    end

    assign target = map_hit_reg ? map_rd_reg : reg_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg         <= op_t'(operation);
            named_reg      <= named;
            var_addr_reg   <= var_addr;
            reg_addr_reg   <= reg_addr;
            reg_ok_reg     <= reg_ok;
            map_hit_reg    <= named && map_valid_reg[var_addr];
            map_rd_reg     <= map_mem[var_addr];
            free_found_reg <= |avail;
            free_idx_reg   <= free_idx;
        end
        if (cmd.lookup)
        begin
            target_reg <= target;
            cnt_rd_reg <= cnt_mem[target];
            live_reg   <= (map_hit_reg || reg_ok_reg) && in_use_reg[target];
        end
        if (cmd.exec)
        begin
            reg_number_reg <= REG_NUM_W'(rnum);
            sole_use_reg   <= sole;
            status_reg     <= st;
        end
    end

    assign cur = live_reg ? cnt_rd_reg : '0;

    always_comb
    begin
        rnum           = '0;
        sole           = 1'b0;
        st             = ST_OK;
        cnt_we         = 1'b0;
        cnt_waddr      = target_reg;
        cnt_wdata      = cur + CNT_ONE;
        map_we         = 1'b0;
        in_use_next    = in_use_reg;
        map_valid_next = map_valid_reg;
        unique case (op_reg) inside
            OP_ASSIGN_VAR, OP_ASSIGN_TMP:
            begin
                if (map_hit_reg)
                begin
                    // A mapped register counts up even after falling to zero.
                    rnum = target_reg;
                    if (cur == CNT_MAX)
                    begin
                        st = ST_SAT;
                    end
                    else if (cmd.exec)
                    begin
                        cnt_we                  = 1'b1;
                        in_use_next[target_reg] = 1'b1;
                    end
                end
                else if (free_found_reg)
                begin
                    rnum      = free_idx_reg;
                    cnt_waddr = free_idx_reg;
                    cnt_wdata = CNT_ONE;
                    if (cmd.exec)
                    begin
                        cnt_we                    = 1'b1;
                        in_use_next[free_idx_reg] = 1'b1;
                        if (named_reg)
                        begin
                            map_we                       = 1'b1;
                            map_valid_next[var_addr_reg] = 1'b1;
                        end
                    end
                end
                else
                begin
                    st = ST_NOREG;
                end
            end
            OP_RELEASE:
            begin
                if (live_reg)
                begin
                    cnt_wdata = cur - CNT_ONE;
                    if (cmd.exec)
                    begin
                        cnt_we = 1'b1;
                        if (cur == CNT_ONE)
                        begin
                            in_use_next[target_reg] = 1'b0;
                        end
                    end
                end
                else
                begin
                    st = ST_UNUSED;
                end
            end
            OP_QUERY:
            begin
                if (live_reg)
                begin
                    sole = (cur == CNT_ONE);
                end
                else
                begin
                    st = ST_UNUSED;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (map_we)
        begin
            map_mem[var_addr_reg] <= free_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            map_valid_reg <= '0;
        end
        else
        begin
            in_use_reg    <= in_use_next;
            map_valid_reg <= map_valid_next;
        end
    end

    assign reg_number = reg_number_reg;
    assign sole_use   = sole_use_reg;
    assign status     = status_reg;

endmodule

// ===== rtl/refcount_register_allocator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// refcount_register_allocator
// Reference-counted register allocator with a variable-to-register map.
// ============================================================================
// A request is accepted when start is high and busy is low. Its result appears
// on reg_number, sole_use and status for the single cycle in which done is high;
// the receiver must take it then, as there is no way to hold it off. A new
// request may be accepted in that same cycle but not before, so each request
// is finished before the next is taken. This comes from two registered reads
// in series: the variable map is read at acceptance, the count table is then
// read at the register that the map or the request names, and the update is
// written back in the execute state. Counts and map entries are qualified by
// flip-flop valid bits, so the block is ready right after reset with no
// clearing pass. first_alloc_reg sits at byte address 0 of the APB port and
// should be written only while the block is idle.
module refcount_register_allocator
    import rcra_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEF,
    parameter int NUM_VARS   = NUM_VARS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       operation,
    input  logic [VAR_W-1:0]      var_index,
    input  logic [REG_W-1:0]      reg_index,
    output logic                  done,
    output logic [REG_NUM_W-1:0]  reg_number,
    output logic                  sole_use,
    output logic [STATUS_W-1:0]   status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    rcra_cmd_t          cmd;
    logic [FIRST_W-1:0] first_alloc_reg_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Byte address bit 2 selects the register; the low bits are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_alloc_reg_reg <= FIRST_ALLOC_RESET;
        end
        else if (cfg_wr && (paddr[2] == CFG_IDX_FIRST_ALLOC))
        begin
            first_alloc_reg_reg <= pwdata[FIRST_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_FIRST_ALLOC)
        begin
            prdata = APB_DATA_W'(first_alloc_reg_reg);
        end
    end

    rcra_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rcra_datapath
    #(
        .NUM_REGS   (NUM_REGS),
        .NUM_VARS   (NUM_VARS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .first_alloc_reg (first_alloc_reg_reg),
        .operation       (operation),
        .var_index       (var_index),
        .reg_index       (reg_index),
        .reg_number      (reg_number),
        .sole_use        (sole_use),
        .status          (status)
    );

    // Every accepted request is followed by its result strobe on done.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("request result not delivered on time");

    // The controller is idle whenever a result is shown.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An exhausted allocation reports register zero.
    a_noreg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOREG)) |-> (reg_number == '0))
        else $error("out-of-registers result carries a register number");

    // Sole use is only ever reported by a successful query.
    a_sole_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && sole_use) |-> (status == ST_OK))
        else $error("sole use reported with an error status");

endmodule

// ===== dv/refcount_register_allocator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// refcount_register_allocator_tb
// Self-checking bench for the register allocator. Requests are driven in
// bursts from a pending queue. A local model of the use counts and the
// variable map predicts each result, and every done strobe is compared with
// the oldest prediction. The first allocatable register is reprogrammed over
// APB between phases, while the allocator is idle.
// ============================================================================
module refcount_register_allocator_tb;
    import rcra_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SAT_RUN     = 258;
    localparam int unsigned COUNT_TOP   = (1 << COUNT_BITS_DEF) - 1;

    typedef struct packed {
        op_t              op;
        logic [VAR_W-1:0] var_idx;
        logic [REG_W-1:0] reg_idx;
    } alloc_req_t;

    typedef struct packed {
        logic [REG_NUM_W-1:0] rnum;
        logic                 sole;
        status_t              st;
    } alloc_rsp_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       operation = '0;
    logic [VAR_W-1:0]      var_index = '0;
    logic [REG_W-1:0]      reg_index = '0;
    logic                  done;
    logic [REG_NUM_W-1:0]  reg_number;
    logic                  sole_use;
    logic [STATUS_W-1:0]   status;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Allocator model state.
    logic [COUNT_BITS_DEF-1:0] use_cnt [NUM_REGS_DEF];
    bit                        var_bound [NUM_VARS_DEF];
    logic [REG_NUM_W-1:0]      var_reg [NUM_VARS_DEF];
    logic [FIRST_W-1:0]        alloc_floor;

    alloc_req_t  pending_reqs [$];
    alloc_rsp_t  expected_rsps [$];
    int unsigned queued_count  = 0;
    int unsigned checked_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;
    logic        req_taken     = 1'b0;

    // Sender burst state, owned by the driver.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    bit          drain_wait = 1'b0;

    refcount_register_allocator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .var_index  (var_index),
        .reg_index  (reg_index),
        .done       (done),
        .reg_number (reg_number),
        .sole_use   (sole_use),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic status_t bump_count(input int unsigned r);
        if (use_cnt[r] >= COUNT_TOP)
        begin
            use_cnt[r] = COUNT_BITS_DEF'(COUNT_TOP);
            return ST_SAT;
        end
        use_cnt[r] = use_cnt[r] + 1'b1;
        return ST_OK;
    endfunction

    function automatic alloc_rsp_t predict_alloc(input op_t op, input logic [VAR_W-1:0] v,
                                                 input logic [REG_W-1:0] r);
        alloc_rsp_t rsp;
        bit         named;
        int         slot;
        rsp.rnum = '0;
        rsp.sole = 1'b0;
        rsp.st   = ST_OK;
        case (op)
            OP_ASSIGN_VAR, OP_ASSIGN_TMP:
            begin
                // A variable number past the map behaves as a temporary.
                named = (op == OP_ASSIGN_VAR) && (v < NUM_VARS_DEF);
                if (named && var_bound[v])
                begin
                    rsp.rnum = var_reg[v];
                    rsp.st   = bump_count(int'(var_reg[v]));
                end
                else
                begin
                    slot = -1;
                    for (int i = int'(alloc_floor); i < NUM_REGS_DEF; i++)
                    begin
                        if (slot < 0 && use_cnt[i] == 0)
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        rsp.st   = bump_count(slot);
                        rsp.rnum = REG_NUM_W'(slot);
                        if (named)
                        begin
                            var_bound[v] = 1'b1;
                            var_reg[v]   = REG_NUM_W'(slot);
                        end
                    end
                    else
                        rsp.st = ST_NOREG;
                end
            end
            OP_RELEASE:
            begin
                if (r < NUM_REGS_DEF && use_cnt[r] != 0)
                    use_cnt[r] = use_cnt[r] - 1'b1;
                else
                    rsp.st = ST_UNUSED;
            end
            default:
            begin
                if (r < NUM_REGS_DEF && use_cnt[r] != 0)
                    rsp.sole = (use_cnt[r] == 1);
                else
                    rsp.st = ST_UNUSED;
            end
        endcase
        return rsp;
    endfunction

    // Request driver: inputs move on the falling edge only.
    always @(negedge clk)
    begin : issue_driver
        alloc_req_t nxt;
        if (rst_n && (!start || req_taken))
        begin
            if (drain_wait && expected_rsps.size() != 0)
                start <= 1'b0;
            else if (gap_left != 0 || pending_reqs.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
            else
            begin
                drain_wait = 1'b0;
                nxt        = pending_reqs.pop_front();
                operation <= nxt.op;
                var_index <= nxt.var_idx;
                reg_index <= nxt.reg_idx;
                start     <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    // Now and then hold off until everything in flight has come back.
                    drain_wait = ($urandom_range(0, 9) == 0);
                end
            end
        end
    end

    // Result checking and prediction at the rising edge. The check comes first
    // so that a result leaving in the cycle of a new request pairs with the older one.
    always @(posedge clk)
    begin : result_check
        alloc_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsps.size() == 0)
                    flag_mismatch($sformatf("result with none pending: reg %0d sole %0d st %0d",
                                            reg_number, sole_use, status));
                else
                begin
                    want = expected_rsps.pop_front();
                    checked_count++;
                    if (reg_number !== want.rnum || sole_use !== want.sole ||
                        status !== want.st)
                        flag_mismatch($sformatf(
                            "got reg %0d sole %0d st %0d, want reg %0d sole %0d st %0d",
                            reg_number, sole_use, status, want.rnum, want.sole, want.st));
                end
            end
            if (start && !busy)
                expected_rsps.push_back(predict_alloc(op_t'(operation), var_index, reg_index));
        end
        req_taken <= rst_n && start && !busy;
    end

    always @(posedge clk)
    begin : cfg_readback
        if (rst_n && psel && penable && !pwrite && pready &&
            prdata !== APB_DATA_W'(alloc_floor))
            flag_mismatch($sformatf("first_alloc_reg read %0d, want %0d", prdata, alloc_floor));
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("refcount_register_allocator_tb: FAIL");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {CFG_IDX_FIRST_ALLOC, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_first_alloc(input logic [FIRST_W-1:0] value);
        apb_access(1'b1, APB_DATA_W'(value));
        alloc_floor = value;
        apb_access(1'b0, '0);
    endtask

    task automatic push_req(input op_t op, input logic [VAR_W-1:0] v,
                            input logic [REG_W-1:0] r);
        alloc_req_t rq;
        rq.op      = op;
        rq.var_idx = v;
        rq.reg_idx = r;
        pending_reqs.push_back(rq);
        queued_count++;
    endtask

    // Every request returns one result, so idle means all queued requests are checked.
    task automatic wait_idle();
        while (checked_count != queued_count)
            @(negedge clk);
    endtask

    // Runs of allocations, runs of releases and queries, and some fully random noise.
    task automatic gen_mixed(input int n);
        int               added;
        int               kind;
        int               len;
        logic [VAR_W-1:0] v;
        logic [REG_W-1:0] r;
        op_t              op;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 8);
            for (int k = 0; k < len && added < n; k++)
            begin
                v = ($urandom_range(0, 4) == 0) ? VAR_W'($urandom_range(26, 31))
                                                : VAR_W'($urandom_range(0, 25));
                r = ($urandom_range(0, 6) == 0) ? REG_W'($urandom_range(0, 31))
                                                : REG_W'($urandom_range(alloc_floor, 31));
                if (kind <= 3)
                    op = ($urandom_range(0, 2) == 0) ? OP_ASSIGN_TMP : OP_ASSIGN_VAR;
                else if (kind <= 6)
                    op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_RELEASE;
                else if (kind <= 8)
                    op = OP_QUERY;
                else
                    op = op_t'($urandom_range(0, 3));
                push_req(op, v, r);
                added++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [VAR_W-1:0]     sat_var;
        logic [REG_NUM_W-1:0] sat_reg;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        for (int i = 0; i < NUM_REGS_DEF; i++)
            use_cnt[i] = '0;
        for (int i = 0; i < NUM_VARS_DEF; i++)
        begin
            var_bound[i] = 1'b0;
            var_reg[i]   = '0;
        end
        alloc_floor = FIRST_ALLOC_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset value of first_alloc_reg.
        push_req(OP_QUERY,      5'd9,  5'd0);
        push_req(OP_RELEASE,    5'd31, 5'd31);
        push_req(OP_ASSIGN_VAR, 5'd0,  5'd17);
        push_req(OP_ASSIGN_VAR, 5'd0,  5'd0);
        push_req(OP_QUERY,      5'd31, 5'd5);
        push_req(OP_ASSIGN_VAR, 5'd25, 5'd31);
        push_req(OP_ASSIGN_VAR, 5'd31, 5'd2);
        push_req(OP_ASSIGN_VAR, 5'd26, 5'd12);
        push_req(OP_ASSIGN_TMP, 5'd10, 5'd21);
        push_req(OP_QUERY,      5'd0,  5'd9);
        push_req(OP_RELEASE,    5'd3,  5'd6);
        push_req(OP_QUERY,      5'd3,  5'd6);
        // A mapped variable whose register dropped to zero uses it again.
        push_req(OP_ASSIGN_VAR, 5'd25, 5'd0);
        push_req(OP_QUERY,      5'd14, 5'd6);
        push_req(OP_RELEASE,    5'd0,  5'd5);
        push_req(OP_RELEASE,    5'd0,  5'd5);
        push_req(OP_RELEASE,    5'd0,  5'd5);
        push_req(OP_ASSIGN_TMP, 5'd31, 5'd31);
        push_req(OP_ASSIGN_VAR, 5'd0,  5'd0);
        push_req(OP_QUERY,      5'd21, 5'd31);
        wait_idle();

        // Only the top register can be handed out, so the pool runs dry at once.
        set_first_alloc(5'd31);
        push_req(OP_ASSIGN_TMP, 5'd4,  5'd10);
        push_req(OP_ASSIGN_TMP, 5'd27, 5'd1);
        push_req(OP_ASSIGN_VAR, 5'd3,  5'd0);
        push_req(OP_ASSIGN_VAR, 5'd0,  5'd31);
        push_req(OP_QUERY,      5'd0,  5'd31);
        push_req(OP_RELEASE,    5'd0,  5'd31);
        push_req(OP_ASSIGN_VAR, 5'd3,  5'd16);
        gen_mixed(60);
        wait_idle();

        set_first_alloc(5'd0);
        gen_mixed(80);
        wait_idle();

        // Drive one variable's count into saturation, step it down once, then back up.
        sat_var = VAR_W'($urandom_range(0, 25));
        for (int i = 0; i < SAT_RUN; i++)
            push_req(OP_ASSIGN_VAR, sat_var, REG_W'($urandom_range(0, 31)));
        wait_idle();
        sat_reg = var_reg[sat_var];
        push_req(OP_QUERY,      VAR_W'($urandom_range(0, 31)), sat_reg);
        push_req(OP_RELEASE,    VAR_W'($urandom_range(0, 31)), sat_reg);
        push_req(OP_ASSIGN_VAR, sat_var, REG_W'($urandom_range(0, 31)));
        push_req(OP_ASSIGN_VAR, sat_var, REG_W'($urandom_range(0, 31)));
        wait_idle();

        set_first_alloc(FIRST_W'($urandom_range(1, 30)));
        gen_mixed(70);
        wait_idle();

        set_first_alloc(FIRST_W'($urandom_range(0, 31)));
        gen_mixed(70);
        wait_idle();

        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("refcount_register_allocator_tb: PASS");
        else
            $display("refcount_register_allocator_tb: FAIL");
        $finish;
    end

endmodule
